FILE: sv/cbad_pkg.sv
package cbad_pkg;

  // Default sizes of the memory regions and of the memory-control block.
  localparam int RAM_BYTES_DEF     = 2097152;
  localparam int SCRATCH_BYTES_DEF = 1024;
  localparam int ROM_BYTES_DEF     = 524288;
  localparam int CONTROL_WORDS_DEF = 9;

  // Fixed points of the memory map (physical addresses unless noted).
  localparam logic [31:0] PHYS_MASK       = 32'h1FFF_FFFF;
  localparam logic [31:0] CACHE_CFG_ADDR  = 32'hFFFE_0130;  // virtual
  localparam logic [31:0] EXP1_BASE       = 32'h1F00_0000;
  localparam logic [31:0] EXP1_LAST       = 32'h1F7F_FFFF;
  localparam logic [31:0] SCRATCH_BASE    = 32'h1F80_0000;
  localparam logic [31:0] MMIO_BASE       = 32'h1F80_1000;
  localparam logic [31:0] MMIO_LAST       = 32'h1F80_3FFF;
  localparam logic [31:0] ROM_BASE        = 32'h1FC0_0000;

  localparam logic [31:0] SERIAL_BASE     = 32'h1F80_1040;
  localparam logic [31:0] SERIAL_LAST     = 32'h1F80_105F;
  localparam logic [31:0] SERIAL_RD_LAST  = 32'h1F80_104F;
  localparam logic [31:0] RAM_SIZE_ADDR   = 32'h1F80_1060;
  localparam logic [31:0] IRQ_STAT_ADDR   = 32'h1F80_1070;
  localparam logic [31:0] IRQ_MASK_ADDR   = 32'h1F80_1074;
  localparam logic [31:0] IRQ_LAST        = 32'h1F80_1077;
  localparam logic [31:0] DMA_BASE        = 32'h1F80_1080;
  localparam logic [31:0] DMA_LAST        = 32'h1F80_10FF;
  localparam logic [31:0] TIMER_BASE      = 32'h1F80_1100;
  localparam logic [31:0] TIMER_LAST      = 32'h1F80_112F;
  localparam logic [31:0] DISC_BASE       = 32'h1F80_1800;
  localparam logic [31:0] DISC_LAST       = 32'h1F80_1803;
  localparam logic [31:0] GPU_DATA_ADDR   = 32'h1F80_1810;
  localparam logic [31:0] GPU_CTRL_ADDR   = 32'h1F80_1814;
  localparam logic [31:0] MDEC_DATA_ADDR  = 32'h1F80_1820;
  localparam logic [31:0] MDEC_CTRL_ADDR  = 32'h1F80_1824;
  localparam logic [31:0] SOUND_BASE      = 32'h1F80_1C00;
  localparam logic [31:0] SOUND_LAST      = 32'h1F80_1FFF;
  localparam logic [31:0] POST_BASE       = 32'h1F80_2000;
  localparam logic [31:0] POST_LAST       = 32'h1F80_2FFF;

  localparam int IRQ_W = 11;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2,
    SZ_WIDE = 2'd3
  } size_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DISCARD  = 2'd1,
    ST_UNMAPPED = 2'd2,
    ST_FAULT    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    TG_REG     = 3'd0,
    TG_RAM     = 3'd1,
    TG_SCRATCH = 3'd2,
    TG_ROM     = 3'd3,
    TG_DEV     = 3'd4,
    TG_OPEN    = 3'd5
  } target_t;

  typedef enum logic [2:0] {
    DEV_SERIAL = 3'd0,
    DEV_DMA    = 3'd1,
    DEV_TIMER  = 3'd2,
    DEV_DISC   = 3'd3,
    DEV_GPU    = 3'd4,
    DEV_SOUND  = 3'd5
  } device_t;

  typedef struct packed {
    logic             mode;
    logic [31:0]      address;
    logic [1:0]       size;
    logic [31:0]      write_data;
    logic             cache_isolated;
    logic [IRQ_W-1:0] irq_raise;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  target;
    logic [2:0]  device;
    logic [28:0] target_address;
    logic [3:0]  byte_enable;
    logic [31:0] lane_data;
    logic [1:0]  read_lane;
    logic [31:0] read_data;
  } res_t;

endpackage

FILE: sv/cbad_chan_if.sv
interface cbad_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/console_bus_address_decoder_core.sv
// The result of an access is registered and valid in the cycle after it is accepted.
// Throughput: one access per cycle, set by the single result register; a waiting
// result does not block a new access when the sink takes it in the same cycle.
// Reset (rst, synchronous, active high) clears the memory-control words, RAM size,
// cache control, interrupt status and mask, and the result valid flag.
module console_bus_address_decoder_core #(
  parameter int RAM_BYTES     = cbad_pkg::RAM_BYTES_DEF,
  parameter int SCRATCH_BYTES = cbad_pkg::SCRATCH_BYTES_DEF,
  parameter int ROM_BYTES     = cbad_pkg::ROM_BYTES_DEF,
  parameter int CONTROL_WORDS = cbad_pkg::CONTROL_WORDS_DEF
) (
  input logic clk,
  input logic rst,
  cbad_chan_if.sink   in_ch,
  cbad_chan_if.source out_ch
);

  // Region limits derived from the parameters. Every bound is a 32-bit
  // physical address so that the decode is a set of plain range compares.
  localparam logic [31:0] RAM_LIMIT    = 32'(RAM_BYTES);
  localparam logic [31:0] SCRATCH_LAST = cbad_pkg::SCRATCH_BASE + 32'(SCRATCH_BYTES - 1);
  localparam logic [31:0] ROM_LAST     = cbad_pkg::ROM_BASE + 32'(ROM_BYTES - 1);
  localparam logic [31:0] CTRL_LAST    = cbad_pkg::MMIO_BASE + 32'(4 * (CONTROL_WORDS - 1));
  localparam int          CIW          = (CONTROL_WORDS > 1) ? $clog2(CONTROL_WORDS) : 1;
  localparam int          IW           = cbad_pkg::IRQ_W;

  // Internal register file of the decoder.
  logic [31:0]   ctrl_words [CONTROL_WORDS];
  logic [31:0]   ram_size_word;
  logic [31:0]   cache_cfg;
  logic [IW-1:0] irq_status;
  logic [IW-1:0] irq_mask;

  // Result register.
  logic             out_valid;
  cbad_pkg::res_t   res;

  // Decode outputs and register updates for the transaction on the input.
  cbad_pkg::res_t   res_next;
  logic [IW-1:0]    irq_status_next;
  logic [IW-1:0]    irq_mask_next;
  logic [31:0]      cache_cfg_next;
  logic [31:0]      ram_size_next;
  logic             ctrl_we;
  logic [CIW-1:0]   ctrl_idx;
  logic             irq_ack;

  logic             in_fire;
  logic             wr;
  logic [1:0]       sz;
  logic [31:0]      szmask;
  logic [31:0]      wd;
  logic [31:0]      p;
  logic [31:0]      off;
  logic [IW-1:0]    irq_raised;

  // A new transaction is taken whenever the result register is empty or
  // is being drained in this same cycle.
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  // Size three behaves as a word; write data is masked to the access size.
  assign wr     = in_ch.data.mode;
  assign sz     = (in_ch.data.size == cbad_pkg::SZ_WIDE) ? cbad_pkg::SZ_WORD : in_ch.data.size;
  assign szmask = (sz == cbad_pkg::SZ_BYTE) ? 32'h0000_00FF :
                  (sz == cbad_pkg::SZ_HALF) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
  assign wd     = in_ch.data.write_data & szmask;
  assign p      = in_ch.data.address & cbad_pkg::PHYS_MASK;
  assign off    = p - cbad_pkg::MMIO_BASE;
  assign ctrl_idx = off[CIW+1:2];

  // Newly raised lines are merged before anything else looks at the status.
  assign irq_raised = irq_status | in_ch.data.irq_raise;

  always_comb begin
    logic [31:0] irq_v;
    logic [31:0] r_data;

    irq_v           = 32'd0;
    r_data          = 32'd0;
    res_next        = '0;
    res_next.target_address = p[28:0];
    irq_status_next = irq_raised;
    irq_mask_next   = irq_mask;
    cache_cfg_next  = cache_cfg;
    ram_size_next   = ram_size_word;
    ctrl_we         = 1'b0;
    irq_ack         = 1'b0;

    if ((in_ch.data.address == cbad_pkg::CACHE_CFG_ADDR) && (sz == cbad_pkg::SZ_WORD)) begin
      // Cache control is reached only by a full word access at its virtual
      // address, even while the cache is isolated.
      if (wr) begin
        cache_cfg_next = wd;
      end else begin
        r_data = cache_cfg;
      end
    end else if (wr && in_ch.data.cache_isolated) begin
      // Isolated cache swallows every other write.
      res_next.status = cbad_pkg::ST_DISCARD;
    end else if (p < RAM_LIMIT) begin
      res_next.target    = cbad_pkg::TG_RAM;
      res_next.lane_data = wr ? wd : 32'd0;
    end else if (p inside {[cbad_pkg::EXP1_BASE : cbad_pkg::EXP1_LAST]}) begin
      // Expansion window: open bus reads as all ones; writes vanish.
      res_next.target = cbad_pkg::TG_OPEN;
      r_data          = wr ? 32'd0 : szmask;
    end else if (p inside {[cbad_pkg::SCRATCH_BASE : SCRATCH_LAST]}) begin
      res_next.target         = cbad_pkg::TG_SCRATCH;
      res_next.target_address = 29'(p - cbad_pkg::SCRATCH_BASE);
      res_next.lane_data      = wr ? wd : 32'd0;
    end else if (p inside {[cbad_pkg::MMIO_BASE : cbad_pkg::MMIO_LAST]}) begin
      if (sz == cbad_pkg::SZ_WORD) begin
        // Word MMIO map.
        if (p <= CTRL_LAST) begin
          if (wr) begin
            ctrl_we = 1'b1;
          end else begin
            r_data = ctrl_words[ctrl_idx];
          end
        end else if (p inside {[cbad_pkg::SERIAL_BASE : cbad_pkg::SERIAL_LAST]}) begin
          res_next.target    = cbad_pkg::TG_DEV;
          res_next.device    = cbad_pkg::DEV_SERIAL;
          res_next.lane_data = wr ? wd : 32'd0;
        end else if (p == cbad_pkg::RAM_SIZE_ADDR) begin
          if (wr) begin
            ram_size_next = wd;
          end else begin
            r_data = ram_size_word;
          end
        end else if (p == cbad_pkg::IRQ_STAT_ADDR) begin
          if (wr) begin
            irq_ack = 1'b1;
          end else begin
            r_data = 32'(irq_raised);
          end
        end else if (p == cbad_pkg::IRQ_MASK_ADDR) begin
          if (wr) begin
            irq_mask_next = wd[IW-1:0];
          end else begin
            r_data = 32'(irq_mask);
          end
        end else if (p inside {[cbad_pkg::DMA_BASE : cbad_pkg::DMA_LAST]}) begin
          res_next.target    = cbad_pkg::TG_DEV;
          res_next.device    = cbad_pkg::DEV_DMA;
          res_next.lane_data = wr ? wd : 32'd0;
        end else if (p inside {[cbad_pkg::TIMER_BASE : cbad_pkg::TIMER_LAST]}) begin
          res_next.target    = cbad_pkg::TG_DEV;
          res_next.device    = cbad_pkg::DEV_TIMER;
          res_next.lane_data = wr ? wd : 32'd0;
        end else if (p inside {[cbad_pkg::DISC_BASE : cbad_pkg::DISC_LAST]}) begin
          res_next.target    = cbad_pkg::TG_DEV;
          res_next.device    = cbad_pkg::DEV_DISC;
          res_next.lane_data = wr ? wd : 32'd0;
        end else if ((p == cbad_pkg::GPU_DATA_ADDR) || (p == cbad_pkg::GPU_CTRL_ADDR)) begin
          res_next.target    = cbad_pkg::TG_DEV;
          res_next.device    = cbad_pkg::DEV_GPU;
          res_next.lane_data = wr ? wd : 32'd0;
        end else if ((p == cbad_pkg::MDEC_DATA_ADDR) || (p == cbad_pkg::MDEC_CTRL_ADDR)) begin
          // Decoder stub: handled here, reads zero.
        end else if (p inside {[cbad_pkg::SOUND_BASE : cbad_pkg::SOUND_LAST]}) begin
          res_next.target    = cbad_pkg::TG_DEV;
          res_next.device    = cbad_pkg::DEV_SOUND;
          res_next.lane_data = wr ? wd : 32'd0;
        end else if (p inside {[cbad_pkg::POST_BASE : cbad_pkg::POST_LAST]}) begin
          // Power-on status stub: handled here, reads zero.
        end else begin
          res_next.status = cbad_pkg::ST_FAULT;
        end
      end else if (sz == cbad_pkg::SZ_HALF) begin
        // Halfword MMIO map.
        if (p inside {[cbad_pkg::SERIAL_BASE : cbad_pkg::SERIAL_LAST]}) begin
          res_next.target    = cbad_pkg::TG_DEV;
          res_next.device    = cbad_pkg::DEV_SERIAL;
          res_next.lane_data = wr ? wd : 32'd0;
        end else if (p == cbad_pkg::IRQ_STAT_ADDR) begin
          if (wr) begin
            irq_ack = 1'b1;
          end else begin
            r_data = 32'(irq_raised);
          end
        end else if (p == cbad_pkg::IRQ_MASK_ADDR) begin
          if (wr) begin
            irq_mask_next = wd[IW-1:0];
          end else begin
            r_data = 32'(irq_mask);
          end
        end else if (p inside {[cbad_pkg::TIMER_BASE : cbad_pkg::TIMER_LAST]}) begin
          res_next.target    = cbad_pkg::TG_DEV;
          res_next.device    = cbad_pkg::DEV_TIMER;
          res_next.lane_data = wr ? wd : 32'd0;
        end else if (p inside {[cbad_pkg::DMA_BASE : cbad_pkg::DMA_LAST]}) begin
          // DMA takes words only: the halfword rides in its lanes.
          res_next.target         = cbad_pkg::TG_DEV;
          res_next.device         = cbad_pkg::DEV_DMA;
          res_next.target_address = {p[28:2], 2'b00};
          if (wr) begin
            res_next.byte_enable = 4'b0011 << {p[1], 1'b0};
            res_next.lane_data   = wd << {p[1], 4'b0000};
          end else begin
            res_next.read_lane = {p[1], 1'b0};
          end
        end else if (p inside {[cbad_pkg::SOUND_BASE : cbad_pkg::SOUND_LAST]}) begin
          res_next.target    = cbad_pkg::TG_DEV;
          res_next.device    = cbad_pkg::DEV_SOUND;
          res_next.lane_data = wr ? wd : 32'd0;
        end else begin
          res_next.status = cbad_pkg::ST_FAULT;
        end
      end else begin
        // Byte MMIO map.
        if (!wr && (p inside {[cbad_pkg::IRQ_STAT_ADDR : cbad_pkg::IRQ_LAST]})) begin
          irq_v  = (p < cbad_pkg::IRQ_MASK_ADDR) ? 32'(irq_raised) : 32'(irq_mask);
          r_data = (irq_v >> {p[1:0], 3'b000}) & 32'h0000_00FF;
        end else if ((p >= cbad_pkg::SERIAL_BASE) &&
                     (p <= (wr ? cbad_pkg::SERIAL_LAST : cbad_pkg::SERIAL_RD_LAST))) begin
          res_next.target         = cbad_pkg::TG_DEV;
          res_next.device         = cbad_pkg::DEV_SERIAL;
          res_next.target_address = {p[28:2], 2'b00};
          res_next.lane_data      = wr ? wd : 32'd0;
        end else if (p inside {[cbad_pkg::DMA_BASE : cbad_pkg::DMA_LAST]}) begin
          res_next.target         = cbad_pkg::TG_DEV;
          res_next.device         = cbad_pkg::DEV_DMA;
          res_next.target_address = {p[28:2], 2'b00};
          if (wr) begin
            res_next.byte_enable = 4'b0001 << p[1:0];
            res_next.lane_data   = wd << {p[1:0], 3'b000};
          end else begin
            res_next.read_lane = p[1:0];
          end
        end else if (p inside {[cbad_pkg::DISC_BASE : cbad_pkg::DISC_LAST]}) begin
          res_next.target    = cbad_pkg::TG_DEV;
          res_next.device    = cbad_pkg::DEV_DISC;
          res_next.lane_data = wr ? wd : 32'd0;
        end else if (p inside {[cbad_pkg::POST_BASE : cbad_pkg::POST_LAST]}) begin
          // Power-on status stub: handled here, reads zero.
        end else begin
          res_next.status = cbad_pkg::ST_FAULT;
        end
      end
    end else if (p inside {[cbad_pkg::ROM_BASE : ROM_LAST]}) begin
      // ROM writes are reported as discarded but still carry their data.
      res_next.target         = cbad_pkg::TG_ROM;
      res_next.target_address = 29'(p - cbad_pkg::ROM_BASE);
      if (wr) begin
        res_next.status    = cbad_pkg::ST_DISCARD;
        res_next.lane_data = wd;
      end
    end else begin
      res_next.status = cbad_pkg::ST_UNMAPPED;
      res_next.target = cbad_pkg::TG_OPEN;
    end

    // Acknowledge clears every status bit whose data bit is zero.
    if (irq_ack) begin
      irq_status_next = irq_raised & wd[IW-1:0];
    end

    res_next.read_data = r_data & szmask;
  end

  // Register state is updated only when a transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CONTROL_WORDS; i++) begin
        ctrl_words[i] <= 32'd0;
      end
      ram_size_word <= 32'd0;
      cache_cfg     <= 32'd0;
      irq_status    <= '0;
      irq_mask      <= '0;
    end else if (in_fire) begin
      if (ctrl_we) begin
        ctrl_words[ctrl_idx] <= wd;
      end
      ram_size_word <= ram_size_next;
      cache_cfg     <= cache_cfg_next;
      irq_status    <= irq_status_next;
      irq_mask      <= irq_mask_next;
    end
  end

  // Result register: loaded on every accepted transaction, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  // Every accepted transaction leaves a result behind.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted transaction produced no result");

  // A raised interrupt line survives unless the same transaction acknowledges.
  a_irq_sticky: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !irq_ack) |=>
      ((irq_status & $past(in_ch.data.irq_raise)) == $past(in_ch.data.irq_raise)))
    else $error("raised interrupt line was lost");

  // A fault carries nothing but the address.
  a_fault_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res.status == cbad_pkg::ST_FAULT)) |->
      ((res.target == cbad_pkg::TG_REG) && (res.lane_data == 32'd0) &&
       (res.read_data == 32'd0) && (res.byte_enable == 4'd0)))
    else $error("undecoded MMIO result carries data");

  // Lane masks are produced only for the DMA device.
  a_be_dma_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res.byte_enable != 4'd0)) |->
      ((res.target == cbad_pkg::TG_DEV) && (res.device == cbad_pkg::DEV_DMA) &&
       (res.target_address[1:0] == 2'b00)))
    else $error("byte enables outside a DMA word write");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule
